FILE: src/masked_column_argmin_selector_assert.svh
// Assertion macros used by the masked column selector datapath.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef MASKED_COLUMN_ARGMIN_SELECTOR_ASSERT_SVH
`define MASKED_COLUMN_ARGMIN_SELECTOR_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define MCAS_CHECK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCAS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mcas_pkg.sv
// Shared types, constants and margin and span functions of the masked column selector.
// No dependencies.
package mcas_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_REGIONS = 16;

	localparam int COL_W     = $clog2(MAX_COLUMNS + 1);
	localparam int ADDR_W    = $clog2(MAX_COLUMNS);
	localparam int REG_IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int COUNT_W   = $clog2(MAX_REGIONS + 1);

	localparam int VAL_W    = 14;
	localparam int POS_W    = 10;
	localparam int HEIGHT_W = 10;
	localparam int WIDTH_W  = 11;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 3;
	localparam int TARGET_W = 10;
	localparam int MARGIN_W = 12;
	localparam int END_W    = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OBS_MARGIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANT_MARGIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OBS_FRAC     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANT_FRAC   = 3'd6;

	typedef enum logic [1:0] {
		REQ_SAMPLE   = 2'd0,
		REQ_OBSTACLE = 2'd1,
		REQ_PLANT    = 2'd2,
		REQ_DECIDE   = 2'd3
	} req_t;

	typedef struct packed {
		logic                 load;
		logic                 prep;
		logic [REG_IDX_W-1:0] idx;
		logic                 scan_issue;
		logic [COL_W-1:0]     col;
		logic                 finish;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0] eff_width;
		logic             out_busy;
	} status_t;

	function automatic logic [MARGIN_W-1:0] margin_of(input logic [POS_W-1:0] width,
			input logic [POS_W-1:0] fixed_m, input logic [POS_W-1:0] frac,
			input logic mode);
		logic [2*POS_W-1:0] prod;
		logic [MARGIN_W-1:0] p;
		prod = width * frac;
		p = prod[2*POS_W-1:8];
		if (!mode)
			return MARGIN_W'(fixed_m);
		return (p == '0) ? MARGIN_W'(1) : p;
	endfunction

	function automatic logic [POS_W-1:0] span_lo(input logic [POS_W-1:0] start,
			input logic [MARGIN_W-1:0] m);
		if (MARGIN_W'(start) < m)
			return '0;
		return POS_W'(MARGIN_W'(start) - m);
	endfunction

	function automatic logic [END_W-1:0] span_end(input logic [POS_W-1:0] start,
			input logic [POS_W-1:0] width, input logic [MARGIN_W-1:0] m);
		return END_W'(start) + END_W'(width) + END_W'(m);
	endfunction

endpackage

FILE: src/masked_column_argmin_selector.sv
// Top level of the masked column selector: controller plus datapath.
// Depends on mcas_pkg, mcas_ctrl, mcas_dp and mcas_ram.
//
// Channel   Handshake            Payload
// input     in_valid/in_ready    req_type, baseline_value, region_start/width/floor_height
// output    out_valid/out_ready  target_column, avoidance_applied, ground_touch_seen,
//                                regions_dropped
// config    cfg_we               cfg_index, cfg_data
//
// Sample and region items are stored as they are accepted; the controller stays idle.
// A decide item runs span prep over all MAX_REGIONS slots, then scans the columns in use
// through the single baseline RAM read port, drains and finishes; a zero width skips the scan.
// A finished result waits in the output register; a following decide holds until it leaves.
// Reset is asynchronous and clears counts and flags; no clearing pass is needed.
module masked_column_argmin_selector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mcas_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcas_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [mcas_pkg::VAL_W-1:0]     baseline_value,
	input  logic [mcas_pkg::POS_W-1:0]     region_start,
	input  logic [mcas_pkg::POS_W-1:0]     region_width,
	input  logic [mcas_pkg::POS_W-1:0]     region_floor_height,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mcas_pkg::TARGET_W-1:0]  target_column,
	output logic                           avoidance_applied,
	output logic                           ground_touch_seen,
	output logic                           regions_dropped
);

	mcas_pkg::cmd_t    cmd;
	mcas_pkg::status_t status;

	mcas_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.status  (status),
		.cmd     (cmd)
	);

	mcas_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.req_type           (req_type),
		.baseline_value     (baseline_value),
		.region_start       (region_start),
		.region_width       (region_width),
		.region_floor_height(region_floor_height),
		.cmd                (cmd),
		.status             (status),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.target_column      (target_column),
		.avoidance_applied  (avoidance_applied),
		.ground_touch_seen  (ground_touch_seen),
		.regions_dropped    (regions_dropped)
	);

endmodule

FILE: src/mcas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mcas_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: src/mcas_ctrl.sv
// Controller of the masked column selector: load, region prep, column scan, result.
// Depends on mcas_pkg.
module mcas_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 req_type,
	input  mcas_pkg::status_t          status,
	output mcas_pkg::cmd_t             cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	logic [mcas_pkg::REG_IDX_W-1:0] idx_q;
	logic [mcas_pkg::COL_W-1:0] col_q;
	logic accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.load = accept && (req_type != mcas_pkg::REQ_DECIDE);
		cmd.prep = (state_q == S_PREP);
		cmd.idx = idx_q;
		cmd.scan_issue = (state_q == S_SCAN);
		cmd.col = col_q;
		cmd.finish = (state_q == S_DONE) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			col_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && req_type == mcas_pkg::REQ_DECIDE) begin
						state_q <= S_PREP;
						idx_q <= '0;
					end
				end
				S_PREP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == mcas_pkg::REG_IDX_W'(mcas_pkg::MAX_REGIONS - 1)) begin
						col_q <= '0;
						state_q <= (status.eff_width == '0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					col_q <= col_q + 1'b1;
					if (col_q == status.eff_width - 1'b1)
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_DONE;
				S_DONE: begin
					if (!status.out_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: src/mcas_dp.sv
// Datapath of the masked column selector: registers, stores, span table and minimum.
// Depends on mcas_pkg, mcas_ram and the assertion macro header.
`include "masked_column_argmin_selector_assert.svh"

module mcas_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcas_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcas_pkg::CFG_W-1:0]    cfg_data,
	input  logic [1:0]                    req_type,
	input  logic [mcas_pkg::VAL_W-1:0]    baseline_value,
	input  logic [mcas_pkg::POS_W-1:0]    region_start,
	input  logic [mcas_pkg::POS_W-1:0]    region_width,
	input  logic [mcas_pkg::POS_W-1:0]    region_floor_height,
	input  mcas_pkg::cmd_t                cmd,
	output mcas_pkg::status_t             status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mcas_pkg::TARGET_W-1:0] target_column,
	output logic                          avoidance_applied,
	output logic                          ground_touch_seen,
	output logic                          regions_dropped
);

	localparam int R = mcas_pkg::MAX_REGIONS;

	logic [mcas_pkg::WIDTH_W-1:0]  image_width_q;
	logic [mcas_pkg::HEIGHT_W-1:0] image_height_q;
	logic                          bias_mode_q;
	logic [mcas_pkg::POS_W-1:0]    obs_margin_q, plant_margin_q, obs_frac_q, plant_frac_q;

	logic [mcas_pkg::COL_W-1:0]   column_count_q;
	logic [mcas_pkg::COUNT_W-1:0] obs_count_q, plant_count_q;
	logic                         any_touch_q, overflow_q;

	logic [mcas_pkg::POS_W-1:0] obs_start_q [R];
	logic [mcas_pkg::POS_W-1:0] obs_width_q [R];
	logic                       obs_touch_q [R];
	logic [mcas_pkg::POS_W-1:0] plant_start_q [R];
	logic [mcas_pkg::POS_W-1:0] plant_width_q [R];

	logic [mcas_pkg::POS_W-1:0] obs_lo_q [R];
	logic [mcas_pkg::END_W-1:0] obs_end_q [R];
	logic [mcas_pkg::POS_W-1:0] plant_lo_q [R];
	logic [mcas_pkg::END_W-1:0] plant_end_q [R];
	logic [R-1:0]               obs_act_q, plant_act_q;

	logic                        rd_valid_s1;
	logic [mcas_pkg::COL_W-1:0]  col_s1;
	logic [mcas_pkg::VAL_W-1:0]  ram_rdata;
	logic [mcas_pkg::VAL_W-1:0]  best_q;
	logic [mcas_pkg::ADDR_W-1:0] best_col_q;
	logic                        out_valid_q;

	logic applied;
	logic touch_in;
	logic sample_we;
	logic obs_load, plant_load;
	logic [mcas_pkg::MARGIN_W-1:0] obs_m, plant_m;
	logic covered;
	logic [mcas_pkg::VAL_W-1:0] col_val;
	logic counts_in_cap;
	logic frame_cleared;

	assign applied = (plant_count_q != '0) || any_touch_q;
	assign touch_in = (region_floor_height >= image_height_q);
	assign sample_we = cmd.load && (req_type == mcas_pkg::REQ_SAMPLE)
		&& (column_count_q < mcas_pkg::COL_W'(mcas_pkg::MAX_COLUMNS));
	assign obs_load = cmd.load && (req_type == mcas_pkg::REQ_OBSTACLE);
	assign plant_load = cmd.load && (req_type == mcas_pkg::REQ_PLANT);

	assign status = '{
		eff_width: (image_width_q > mcas_pkg::WIDTH_W'(mcas_pkg::MAX_COLUMNS))
			? mcas_pkg::COL_W'(mcas_pkg::MAX_COLUMNS) : mcas_pkg::COL_W'(image_width_q),
		out_busy: out_valid_q && !out_ready
	};

	mcas_ram #(
		.DEPTH(mcas_pkg::MAX_COLUMNS),
		.WIDTH(mcas_pkg::VAL_W)
	) u_baseline_ram (
		.clk  (clk),
		.we   (sample_we),
		.waddr(column_count_q[mcas_pkg::ADDR_W-1:0]),
		.wdata(baseline_value),
		.raddr(cmd.col[mcas_pkg::ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign obs_m = mcas_pkg::margin_of(obs_width_q[cmd.idx], obs_margin_q, obs_frac_q,
		bias_mode_q);
	assign plant_m = mcas_pkg::margin_of(plant_width_q[cmd.idx], plant_margin_q,
		plant_frac_q, bias_mode_q);

	always_comb begin
		covered = 1'b0;
		for (int i = 0; i < R; i++) begin
			if (obs_act_q[i] && mcas_pkg::END_W'(col_s1) >= mcas_pkg::END_W'(obs_lo_q[i])
					&& mcas_pkg::END_W'(col_s1) < obs_end_q[i])
				covered = 1'b1;
			if (plant_act_q[i] && mcas_pkg::END_W'(col_s1) >= mcas_pkg::END_W'(plant_lo_q[i])
					&& mcas_pkg::END_W'(col_s1) < plant_end_q[i])
				covered = 1'b1;
		end
		if (covered)
			col_val = {image_height_q, 4'b0000};
		else if (col_s1 >= column_count_q)
			col_val = '0;
		else
			col_val = ram_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= mcas_pkg::WIDTH_W'(240);
			image_height_q <= mcas_pkg::HEIGHT_W'(520);
			bias_mode_q <= 1'b0;
			obs_margin_q <= '0;
			plant_margin_q <= '0;
			obs_frac_q <= mcas_pkg::POS_W'(128);
			plant_frac_q <= mcas_pkg::POS_W'(179);
			column_count_q <= '0;
			obs_count_q <= '0;
			plant_count_q <= '0;
			any_touch_q <= 1'b0;
			overflow_q <= 1'b0;
			obs_act_q <= '0;
			plant_act_q <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mcas_pkg::CFG_IMAGE_WIDTH:  image_width_q <= cfg_data;
					mcas_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[mcas_pkg::HEIGHT_W-1:0];
					mcas_pkg::CFG_BIAS_MODE:    bias_mode_q <= cfg_data[0];
					mcas_pkg::CFG_OBS_MARGIN:   obs_margin_q <= cfg_data[mcas_pkg::POS_W-1:0];
					mcas_pkg::CFG_PLANT_MARGIN: plant_margin_q <= cfg_data[mcas_pkg::POS_W-1:0];
					mcas_pkg::CFG_OBS_FRAC:     obs_frac_q <= cfg_data[mcas_pkg::POS_W-1:0];
					mcas_pkg::CFG_PLANT_FRAC:   plant_frac_q <= cfg_data[mcas_pkg::POS_W-1:0];
					default: ;
				endcase
			end
			if (sample_we)
				column_count_q <= column_count_q + 1'b1;
			if (obs_load) begin
				if (obs_count_q < mcas_pkg::COUNT_W'(R)) begin
					obs_count_q <= obs_count_q + 1'b1;
					any_touch_q <= any_touch_q | touch_in;
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (plant_load) begin
				if (plant_count_q < mcas_pkg::COUNT_W'(R))
					plant_count_q <= plant_count_q + 1'b1;
				else
					overflow_q <= 1'b1;
			end
			if (cmd.prep) begin
				obs_act_q[cmd.idx] <= applied
					&& (mcas_pkg::COUNT_W'(cmd.idx) < obs_count_q) && obs_touch_q[cmd.idx];
				plant_act_q[cmd.idx] <= applied
					&& (mcas_pkg::COUNT_W'(cmd.idx) < plant_count_q);
			end
			rd_valid_s1 <= cmd.scan_issue;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.finish) begin
				column_count_q <= '0;
				obs_count_q <= '0;
				plant_count_q <= '0;
				any_touch_q <= 1'b0;
				overflow_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (obs_load && obs_count_q < mcas_pkg::COUNT_W'(R)) begin
			obs_start_q[obs_count_q[mcas_pkg::REG_IDX_W-1:0]] <= region_start;
			obs_width_q[obs_count_q[mcas_pkg::REG_IDX_W-1:0]] <= region_width;
			obs_touch_q[obs_count_q[mcas_pkg::REG_IDX_W-1:0]] <= touch_in;
		end
		if (plant_load && plant_count_q < mcas_pkg::COUNT_W'(R)) begin
			plant_start_q[plant_count_q[mcas_pkg::REG_IDX_W-1:0]] <= region_start;
			plant_width_q[plant_count_q[mcas_pkg::REG_IDX_W-1:0]] <= region_width;
		end
		if (cmd.prep) begin
			obs_lo_q[cmd.idx] <= mcas_pkg::span_lo(obs_start_q[cmd.idx], obs_m);
			obs_end_q[cmd.idx] <= mcas_pkg::span_end(obs_start_q[cmd.idx],
				obs_width_q[cmd.idx], obs_m);
			plant_lo_q[cmd.idx] <= mcas_pkg::span_lo(plant_start_q[cmd.idx], plant_m);
			plant_end_q[cmd.idx] <= mcas_pkg::span_end(plant_start_q[cmd.idx],
				plant_width_q[cmd.idx], plant_m);
			best_col_q <= '0;
		end
		col_s1 <= cmd.col;
		if (rd_valid_s1) begin
			if (col_s1 == '0 || col_val < best_q) begin
				best_q <= col_val;
				best_col_q <= col_s1[mcas_pkg::ADDR_W-1:0];
			end
		end
		if (cmd.finish) begin
			target_column <= mcas_pkg::TARGET_W'(best_col_q);
			avoidance_applied <= applied;
			ground_touch_seen <= any_touch_q;
			regions_dropped <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;

	assign counts_in_cap = (obs_count_q <= mcas_pkg::COUNT_W'(R))
		&& (plant_count_q <= mcas_pkg::COUNT_W'(R));
	assign frame_cleared = (column_count_q == '0) && (obs_count_q == '0)
		&& (plant_count_q == '0) && out_valid_q;

	`MCAS_CHECK(a_finish_free, !cmd.finish || !(out_valid_q && !out_ready), "result overwritten")
	`MCAS_CHECK(a_count_cap, counts_in_cap, "region count beyond capacity")
	`MCAS_CHECK_NEXT(a_frame_clear, cmd.finish, frame_cleared, "frame not cleared after decide")
	`MCAS_CHECK(a_scan_range, !cmd.scan_issue || cmd.col < status.eff_width, "column scan beyond width")

endmodule
